>>> hw/rtl/lrt_pkg.sv
package lrt_pkg;

	// Sizes and defaults
	localparam int NODE_COUNT_DEF = 16;
	localparam int RATE_FRAC_BITS = 8;
	localparam int CFG_INDEX_W    = 3;
	localparam int IN_DATA_W      = 216;
	localparam int OUT_DATA_W     = 200;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_LATENCY_TARGET  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_RATE_FLOOR      = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_RATE_CEILING    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_INTERVAL = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_COOLDOWN        = 3'd4;

	// Configuration reset values
	localparam logic [31:0] LATENCY_TARGET_RST = 32'd1000;
	localparam logic [31:0] RATE_FLOOR_RST     = 32'(64'd1 << RATE_FRAC_BITS);
	localparam logic [31:0] RATE_CEILING_RST   = 32'hFFFF_FFFF;

	// Item kinds
	localparam logic KIND_REGISTER = 1'b0;
	localparam logic KIND_TICK     = 1'b1;

	typedef enum logic [1:0] {
		POL_FIXED    = 2'd0,
		POL_CONSERV  = 2'd1,
		POL_AGGRESS  = 2'd2,
		POL_HOLD     = 2'd3   // evaluated and logged, never adjusted
	} policy_t;

	typedef enum logic [2:0] {
		ST_REGISTERED = 3'd0,
		ST_UNCHANGED  = 3'd1,
		ST_ADJUSTED   = 3'd2,
		ST_SKIPPED    = 3'd3,
		ST_UNKNOWN    = 3'd4
	} status_t;

	typedef struct packed {
		logic        kind;
		logic [3:0]  node;
		logic [1:0]  policy;
		logic [31:0] start_rate;
		logic [31:0] node_ceiling;
		logic [47:0] now_us;
		logic [31:0] median_latency;
		logic [31:0] tail_latency;
		logic [31:0] mean_latency;
		logic        stats_present;
	} item_t;

	typedef struct packed {
		logic [31:0] latency_target;
		logic [31:0] rate_floor;
		logic [31:0] rate_ceiling;
		logic [31:0] sample_interval;
		logic [31:0] cooldown;
	} cfg_t;

	typedef struct packed {
		policy_t     policy;
		logic [31:0] rate;
		logic [31:0] ceiling;
		logic [47:0] last_adjust;
		logic [47:0] last_sample;
		logic [31:0] adjust_count;
		logic [31:0] low_seen;
		logic [31:0] high_seen;
		logic [31:0] tail;
		logic [31:0] mean;
	} slot_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] rate_now;
		logic        resync;
		logic [31:0] adjust_total;
		logic [31:0] lowest_rate;
		logic [31:0] highest_rate;
		logic [31:0] recent_tail;
		logic [31:0] recent_mean;
	} result_t;

endpackage

>>> hw/rtl/latency_driven_rate_tuner_unit.sv
// An accepted item is held in the input register, then its result in the result register.
// Throughput: one item per cycle while the result side keeps taking results;
// the whole slot read-modify-write sits between the input and result registers.
// Reset (arst_n low, asynchronous): all slots become unregistered, handshake
// state clears and configuration returns to its defaults. No clearing pass;
// the block can take items as soon as reset is released.
module latency_driven_rate_tuner_unit import lrt_pkg::*; #(
	parameter int NODE_COUNT = NODE_COUNT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Item input
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// node[3:0], policy[5:4], start_rate[37:6], node_ceiling[69:38], now_us[117:70],
	// median_latency[149:118], tail_latency[181:150], mean_latency[213:182],
	// stats_present[214], zero pad[215]
	input  logic [IN_DATA_W-1:0]   s_tdata,
	// kind[0]
	input  logic                   s_tuser,
	// Result output
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// rate_now[31:0], resync[32], adjust_total[64:33], lowest_rate[96:65],
	// highest_rate[128:97], recent_tail[160:129], recent_mean[192:161], zero pad[199:193]
	output logic [OUT_DATA_W-1:0]  m_tdata,
	// status[2:0]
	output logic [2:0]             m_tuser,
	// Configuration write
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]            cfg_data
);

	localparam int NODE_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

	cfg_t              cfg;
	item_t             item_in;
	item_t             item_s1;
	logic              valid_s1;
	logic              advance;
	logic              out_valid_q;
	result_t           result_q;
	logic              rd_valid;
	slot_t             rd_slot;
	logic              wr_en;
	slot_t             wr_slot;
	result_t           res;
	logic [NODE_W-1:0] slot_idx;

	// Unpack the input item
	assign item_in.kind           = s_tuser;
	assign item_in.node           = s_tdata[3:0];
	assign item_in.policy         = s_tdata[5:4];
	assign item_in.start_rate     = s_tdata[37:6];
	assign item_in.node_ceiling   = s_tdata[69:38];
	assign item_in.now_us         = s_tdata[117:70];
	assign item_in.median_latency = s_tdata[149:118];
	assign item_in.tail_latency   = s_tdata[181:150];
	assign item_in.mean_latency   = s_tdata[213:182];
	assign item_in.stats_present  = s_tdata[214];

	lrt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Input register
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= item_in;
		end
	end

	assign slot_idx = NODE_W'(item_s1.node);

	lrt_table #(
		.NODE_COUNT (NODE_COUNT)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_idx   (slot_idx),
		.rd_valid (rd_valid),
		.rd_slot  (rd_slot),
		.we       (advance && wr_en),
		.wr_idx   (slot_idx),
		.wr_slot  (wr_slot)
	);

	lrt_eval #(
		.NODE_COUNT (NODE_COUNT)
	) u_eval (
		.item       (item_s1),
		.cfg        (cfg),
		.slot_valid (rd_valid),
		.slot       (rd_slot),
		.wr_en      (wr_en),
		.wr_slot    (wr_slot),
		.res        (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = result_q.status;
	assign m_tdata  = {7'b0, result_q.recent_mean, result_q.recent_tail,
		result_q.highest_rate, result_q.lowest_rate, result_q.adjust_total,
		result_q.resync, result_q.rate_now};

	a_rate_in_history: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (result_q.lowest_rate <= result_q.rate_now)
			&& (result_q.rate_now <= result_q.highest_rate))
		else $error("rate outside its recorded low/high range");

	a_unknown_is_blank: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (result_q.status == ST_UNKNOWN)) |->
			(result_q.rate_now == '0) && !result_q.resync && (result_q.adjust_total == '0)
			&& (result_q.recent_tail == '0) && (result_q.recent_mean == '0))
		else $error("unknown-node result carries slot data");

	a_stalled_item_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("stalled item dropped from input register");

endmodule

>>> hw/rtl/lrt_cfg.sv
module lrt_cfg import lrt_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]            cfg_data,
	output cfg_t                   cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	// Register file; writes to unused indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.latency_target  <= LATENCY_TARGET_RST;
			cfg_q.rate_floor      <= RATE_FLOOR_RST;
			cfg_q.rate_ceiling    <= RATE_CEILING_RST;
			cfg_q.sample_interval <= '0;
			cfg_q.cooldown        <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_LATENCY_TARGET:  cfg_q.latency_target  <= cfg_data;
				CFG_RATE_FLOOR:      cfg_q.rate_floor      <= cfg_data;
				CFG_RATE_CEILING:    cfg_q.rate_ceiling    <= cfg_data;
				CFG_SAMPLE_INTERVAL: cfg_q.sample_interval <= cfg_data;
				CFG_COOLDOWN:        cfg_q.cooldown        <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule

>>> hw/rtl/lrt_table.sv
module lrt_table import lrt_pkg::*; #(
	parameter int NODE_COUNT = NODE_COUNT_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic [((NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1)-1:0] rd_idx,
	output logic                                         rd_valid,
	output slot_t                                        rd_slot,
	input  logic                                         we,
	input  logic [((NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1)-1:0] wr_idx,
	input  slot_t                                        wr_slot
);

	logic [NODE_COUNT-1:0] valid_q;
	slot_t                 slots_q [NODE_COUNT];

	// Valid bits clear on reset; slot contents only mean something once valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[wr_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			slots_q[wr_idx] <= wr_slot;
		end
	end

	// Single read port, combinational
	assign rd_valid = valid_q[rd_idx];
	assign rd_slot  = slots_q[rd_idx];

	a_write_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		we |=> valid_q[$past(wr_idx)])
		else $error("slot written but not marked valid");

endmodule

>>> hw/rtl/lrt_eval.sv
module lrt_eval import lrt_pkg::*; #(
	parameter int NODE_COUNT = NODE_COUNT_DEF
) (
	input  item_t   item,
	input  cfg_t    cfg,
	input  logic    slot_valid,
	input  slot_t   slot,
	output logic    wr_en,
	output slot_t   wr_slot,
	output result_t res
);

	// ceil(2^34 / 5): (x * DIV5_RECIP) >> 34 is exact x / 5 for any 32-bit x
	localparam logic [31:0] DIV5_RECIP = 32'hCCCC_CCCD;

	// floor(4r/5) for remainder r of a divide by 5
	function automatic logic [2:0] frac_4_5(input logic [2:0] r);
		logic [2:0] f;
		unique case (r)
			3'd0, 3'd1: f = 3'd0;
			3'd2:       f = 3'd1;
			3'd3:       f = 3'd2;
			3'd4:       f = 3'd3;
			default:    f = 3'd0;
		endcase
		return f;
	endfunction

	// floor(6r/5)
	function automatic logic [2:0] frac_6_5(input logic [2:0] r);
		logic [2:0] f;
		unique case (r)
			3'd0:    f = 3'd0;
			3'd1:    f = 3'd1;
			3'd2:    f = 3'd2;
			3'd3:    f = 3'd3;
			3'd4:    f = 3'd4;
			default: f = 3'd0;
		endcase
		return f;
	endfunction

	// floor(7r/10) for remainder r of a divide by 10
	function automatic logic [2:0] frac_7_10(input logic [3:0] r);
		logic [2:0] f;
		unique case (r)
			4'd0, 4'd1: f = 3'd0;
			4'd2:       f = 3'd1;
			4'd3, 4'd4: f = 3'd2;
			4'd5:       f = 3'd3;
			4'd6, 4'd7: f = 3'd4;
			4'd8:       f = 3'd5;
			4'd9:       f = 3'd6;
			default:    f = 3'd0;
		endcase
		return f;
	endfunction

	logic        in_range;
	logic [63:0] recip_prod;
	logic [29:0] q5;
	logic [31:0] q5_times5;
	logic [2:0]  r5;
	logic [28:0] q10;
	logic [3:0]  r10;
	logic [32:0] cut_cons, raise_cons, cut_aggr, raise_aggr;
	logic        tail_high, tail_low, med_high, med_low;
	logic [38:0] med_x100, tgt_x33;
	logic [47:0] since_sample, since_adjust;
	logic        cool, above_floor;
	logic [31:0] hi_lim;
	logic        want_adj, do_adj;
	logic [32:0] nv_raw;
	logic [31:0] nv;
	status_t     status;

	assign in_range = (32'(item.node) < 32'(NODE_COUNT));

	// Divide the current rate by 5 and by 10 once; every scale is built from these
	assign recip_prod = 64'(slot.rate) * 64'(DIV5_RECIP);
	assign q5         = recip_prod[63:34];
	assign q5_times5  = {q5, 2'b00} + 32'(q5);
	assign r5         = 3'(slot.rate - q5_times5);
	assign q10        = q5[29:1];
	assign r10        = q5[0] ? (4'(r5) + 4'd5) : 4'(r5);

	// x*4/5, x*6/5, x*7/10, x*11/10 as quotient times k plus floor(k*rem/d)
	assign cut_cons   = 33'({q5, 2'b00}) + 33'(frac_4_5(r5));
	assign raise_aggr = 33'({q5, 2'b00}) + 33'({q5, 1'b0}) + 33'(frac_6_5(r5));
	assign cut_aggr   = 33'({q10, 3'b000}) - 33'(q10) + 33'(frac_7_10(r10));
	// floor(11r/10) equals r for r below 10
	assign raise_cons = 33'({q10, 3'b000}) + 33'({q10, 1'b0}) + 33'(q10) + 33'(r10);

	// Latency thresholds, exact
	assign tail_high = item.tail_latency > cfg.latency_target;
	assign tail_low  = {item.tail_latency, 1'b0} < {1'b0, cfg.latency_target};
	assign med_high  = item.median_latency > cfg.latency_target;
	assign med_x100  = (39'(item.median_latency) << 6) + (39'(item.median_latency) << 5)
		+ (39'(item.median_latency) << 2);
	assign tgt_x33   = (39'(cfg.latency_target) << 5) + 39'(cfg.latency_target);
	assign med_low   = med_x100 < tgt_x33;

	// Elapsed times wrap modulo 2^48
	assign since_sample = item.now_us - slot.last_sample;
	assign since_adjust = item.now_us - slot.last_adjust;
	assign cool         = since_adjust > {16'b0, cfg.cooldown};
	assign above_floor  = slot.rate > cfg.rate_floor;
	assign hi_lim       = (slot.ceiling < cfg.rate_ceiling) ? slot.ceiling : cfg.rate_ceiling;

	// Strategy: a cut has priority over a raise
	always_comb begin
		want_adj = 1'b0;
		nv_raw   = 33'(slot.rate);
		unique case (slot.policy)
			POL_CONSERV: begin
				priority if (tail_high && above_floor) begin
					want_adj = 1'b1;
					nv_raw   = cut_cons;
				end else if (tail_low && cool) begin
					want_adj = 1'b1;
					nv_raw   = raise_cons;
				end else begin
					want_adj = 1'b0;
				end
			end
			POL_AGGRESS: begin
				priority if (med_high && above_floor) begin
					want_adj = 1'b1;
					nv_raw   = cut_aggr;
				end else if (med_low && cool) begin
					want_adj = 1'b1;
					nv_raw   = raise_aggr;
				end else begin
					want_adj = 1'b0;
				end
			end
			default: begin
				want_adj = 1'b0;
			end
		endcase
	end

	// Clamp, floor checked first so it wins over a lower ceiling
	always_comb begin
		priority if (nv_raw < {1'b0, cfg.rate_floor}) begin
			nv = cfg.rate_floor;
		end else if (nv_raw > {1'b0, hi_lim}) begin
			nv = hi_lim;
		end else begin
			nv = nv_raw[31:0];
		end
	end

	assign do_adj = want_adj && (nv != slot.rate);

	// Slot update and status
	always_comb begin
		wr_en   = 1'b0;
		wr_slot = slot;
		status  = ST_UNKNOWN;
		priority if (!in_range) begin
			status = ST_UNKNOWN;
		end else if (item.kind == KIND_REGISTER) begin
			status = ST_REGISTERED;
			if (!slot_valid) begin
				wr_en                = 1'b1;
				wr_slot.policy       = policy_t'(item.policy);
				wr_slot.rate         = item.start_rate;
				wr_slot.ceiling      = item.node_ceiling;
				wr_slot.last_adjust  = '0;
				wr_slot.last_sample  = '0;
				wr_slot.adjust_count = '0;
				wr_slot.low_seen     = item.start_rate;
				wr_slot.high_seen    = item.start_rate;
				wr_slot.tail         = '0;
				wr_slot.mean         = '0;
			end
		end else if (!slot_valid) begin
			status = ST_UNKNOWN;
		end else if (slot.policy == POL_FIXED) begin
			status = ST_SKIPPED;
		end else if (since_sample < {16'b0, cfg.sample_interval}) begin
			status = ST_SKIPPED;
		end else begin
			wr_en               = 1'b1;
			wr_slot.last_sample = item.now_us;
			if (!item.stats_present) begin
				status = ST_SKIPPED;
			end else begin
				wr_slot.tail = item.tail_latency;
				wr_slot.mean = item.mean_latency;
				if (do_adj) begin
					status              = ST_ADJUSTED;
					wr_slot.rate        = nv;
					wr_slot.last_adjust = item.now_us;
					if (slot.adjust_count != '1) begin
						wr_slot.adjust_count = slot.adjust_count + 32'd1;
					end
					if (nv < slot.low_seen) begin
						wr_slot.low_seen = nv;
					end
					if (nv > slot.high_seen) begin
						wr_slot.high_seen = nv;
					end
				end else begin
					status = ST_UNCHANGED;
				end
			end
		end
	end

	// Result shows the slot after the update; zeros for an unknown node
	always_comb begin
		res        = '0;
		res.status = status;
		if (status != ST_UNKNOWN) begin
			res.rate_now     = wr_slot.rate;
			res.resync       = (status == ST_ADJUSTED);
			res.adjust_total = wr_slot.adjust_count;
			res.lowest_rate  = wr_slot.low_seen;
			res.highest_rate = wr_slot.high_seen;
			res.recent_tail  = wr_slot.tail;
			res.recent_mean  = wr_slot.mean;
		end
	end

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps

module tb import lrt_pkg::*; ();

	localparam int STALL_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic s_tvalid = 1'b0;
	logic s_tready;
	// node, policy, start_rate, node_ceiling, now_us, median, tail, mean, stats, pad
	logic [IN_DATA_W-1:0] s_tdata = '0;
	// kind
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// rate_now, resync, adjust_total, lowest, highest, recent_tail, recent_mean, pad
	logic [OUT_DATA_W-1:0] m_tdata;
	// status
	logic [2:0] m_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	latency_driven_rate_tuner_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow of the tuner: configuration and node table
	logic [31:0] target_us   = LATENCY_TARGET_RST;
	logic [31:0] floor_rate  = RATE_FLOOR_RST;
	logic [31:0] ceil_rate   = RATE_CEILING_RST;
	logic [31:0] sample_gap  = '0;
	logic [31:0] raise_wait  = '0;
	logic [15:0] node_live   = '0;
	slot_t       node_tab [16];

	result_t     due_reports [$];
	int          bad_reports = 0;
	int          send_idle = 0;
	int          stall_pct = 0;
	int          quiet_cycles = 0;
	logic [47:0] clock_us = '0;
	result_t     want, got;

	initial begin
		forever #2 clk = ~clk;
	end

	// Result side backpressure
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// Expected report for one item; updates the shadow table
	function automatic result_t evaluate_node(input item_t it);
		result_t     r;
		logic [3:0]  n;
		logic [47:0] gap, since_adj;
		logic [63:0] cur, nv, hi, p50, p99, tgt;
		logic        bump, cool;
		n = it.node;
		r = '0;
		if (it.kind == KIND_REGISTER) begin
			if (!node_live[n]) begin
				node_live[n] = 1'b1;
				node_tab[n].policy = policy_t'(it.policy);
				node_tab[n].rate = it.start_rate;
				node_tab[n].ceiling = it.node_ceiling;
				node_tab[n].last_adjust = '0;
				node_tab[n].last_sample = '0;
				node_tab[n].adjust_count = '0;
				node_tab[n].low_seen = it.start_rate;
				node_tab[n].high_seen = it.start_rate;
				node_tab[n].tail = '0;
				node_tab[n].mean = '0;
			end
			r.status = ST_REGISTERED;
		end else if (!node_live[n]) begin
			r.status = ST_UNKNOWN;
		end else if (node_tab[n].policy == POL_FIXED) begin
			r.status = ST_SKIPPED;
		end else begin
			gap = it.now_us - node_tab[n].last_sample;
			if (gap < {16'd0, sample_gap}) begin
				r.status = ST_SKIPPED;
			end else begin
				node_tab[n].last_sample = it.now_us;
				if (!it.stats_present) begin
					r.status = ST_SKIPPED;
				end else begin
					cur = {32'd0, node_tab[n].rate};
					nv = cur;
					bump = 1'b0;
					p50 = {32'd0, it.median_latency};
					p99 = {32'd0, it.tail_latency};
					tgt = {32'd0, target_us};
					since_adj = it.now_us - node_tab[n].last_adjust;
					cool = since_adj > {16'd0, raise_wait};
					case (node_tab[n].policy)
						POL_CONSERV: begin
							if (p99 > tgt && cur > {32'd0, floor_rate}) begin
								nv = cur * 4 / 5;
								bump = 1'b1;
							end else if (2 * p99 < tgt && cool) begin
								nv = cur * 11 / 10;
								bump = 1'b1;
							end
						end
						POL_AGGRESS: begin
							if (p50 > tgt && cur > {32'd0, floor_rate}) begin
								nv = cur * 7 / 10;
								bump = 1'b1;
							end else if (100 * p50 < 33 * tgt && cool) begin
								nv = cur * 6 / 5;
								bump = 1'b1;
							end
						end
						default: ;
					endcase
					// floor is tested first, so it wins over a lower ceiling
					hi = (node_tab[n].ceiling < ceil_rate) ? {32'd0, node_tab[n].ceiling}
						: {32'd0, ceil_rate};
					if (nv < {32'd0, floor_rate})
						nv = {32'd0, floor_rate};
					else if (nv > hi)
						nv = hi;
					if (bump && nv != cur) begin
						node_tab[n].rate = nv[31:0];
						if (node_tab[n].adjust_count != 32'hFFFF_FFFF)
							node_tab[n].adjust_count += 1;
						node_tab[n].last_adjust = it.now_us;
						if (nv[31:0] < node_tab[n].low_seen)
							node_tab[n].low_seen = nv[31:0];
						if (nv[31:0] > node_tab[n].high_seen)
							node_tab[n].high_seen = nv[31:0];
						r.status = ST_ADJUSTED;
					end else begin
						r.status = ST_UNCHANGED;
					end
					node_tab[n].tail = it.tail_latency;
					node_tab[n].mean = it.mean_latency;
				end
			end
		end
		if (r.status != ST_UNKNOWN) begin
			r.rate_now = node_tab[n].rate;
			r.resync = (r.status == ST_ADJUSTED);
			r.adjust_total = node_tab[n].adjust_count;
			r.lowest_rate = node_tab[n].low_seen;
			r.highest_rate = node_tab[n].high_seen;
			r.recent_tail = node_tab[n].tail;
			r.recent_mean = node_tab[n].mean;
		end
		return r;
	endfunction

	// Latency value near one of the decision thresholds, or anywhere
	function automatic logic [31:0] pick_latency();
		logic [63:0] t;
		t = {32'd0, target_us};
		case ($urandom_range(4))
			0: pick_latency = $urandom_range(32'(t / 3));
			1: pick_latency = 32'(t / 2) + $urandom_range(2) - 1;
			2: pick_latency = 32'(t + 1 + $urandom_range(2000));
			3: pick_latency = $urandom;
			default: pick_latency = 32'(t * 33 / 100) + $urandom_range(2) - 1;
		endcase
	endfunction

	// One item onto the input stream; valid stays up for back-to-back items
	task automatic send_item(input item_t it);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, it.stats_present, it.mean_latency, it.tail_latency,
			it.median_latency, it.now_us, it.node_ceiling, it.start_rate,
			it.policy, it.node};
		s_tuser <= it.kind;
		do @(posedge clk); while (!s_tready);
		due_reports.push_back(evaluate_node(it));
		@(negedge clk);
	endtask

	task automatic reg_node(input logic [3:0] n, input policy_t pol,
		input logic [31:0] start, input logic [31:0] ceil);
		item_t it;
		it = '0;
		it.kind = KIND_REGISTER;
		it.node = n;
		it.policy = pol;
		it.start_rate = start;
		it.node_ceiling = ceil;
		send_item(it);
	endtask

	task automatic tick_node(input logic [3:0] n, input logic [47:0] now,
		input logic [31:0] p50, input logic [31:0] p99, input logic [31:0] mean,
		input logic stats);
		item_t it;
		it = '0;
		it.kind = KIND_TICK;
		it.node = n;
		it.now_us = now;
		it.median_latency = p50;
		it.tail_latency = p99;
		it.mean_latency = mean;
		it.stats_present = stats;
		send_item(it);
	endtask

	// Stop sending and wait for every outstanding report
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (due_reports.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_LATENCY_TARGET:  target_us = val;
			CFG_RATE_FLOOR:      floor_rate = val;
			CFG_RATE_CEILING:    ceil_rate = val;
			CFG_SAMPLE_INTERVAL: sample_gap = val;
			CFG_COOLDOWN:        raise_wait = val;
			default: ;
		endcase
		@(negedge clk);
	endtask

	// New settings, written only once the block is idle
	task automatic apply_settings(input logic [31:0] tgt, input logic [31:0] flr,
		input logic [31:0] ceil, input logic [31:0] gap, input logic [31:0] cool);
		drain_results();
		write_reg(CFG_LATENCY_TARGET, tgt);
		write_reg(CFG_RATE_FLOOR, flr);
		write_reg(CFG_RATE_CEILING, ceil);
		write_reg(CFG_SAMPLE_INTERVAL, gap);
		write_reg(CFG_COOLDOWN, cool);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Mostly ticks on a moving clock, with some registrations mixed in
	task automatic random_phase(input int count, input int hold_at);
		item_t it;
		for (int i = 0; i < count; i++) begin
			if (i == hold_at)
				drain_results();
			it.kind = ($urandom_range(99) < 12) ? KIND_REGISTER : KIND_TICK;
			it.node = 4'($urandom_range(15));
			it.policy = 2'($urandom_range(3));
			case ($urandom_range(3))
				0: it.start_rate = $urandom;
				1: it.start_rate = '0;
				default: it.start_rate = $urandom_range(32'h100, 32'h10_0000);
			endcase
			case ($urandom_range(3))
				0: it.node_ceiling = $urandom;
				1: it.node_ceiling = 32'hFFFF_FFFF;
				default: it.node_ceiling = $urandom_range(32'h1000, 32'h100_0000);
			endcase
			clock_us += 48'($urandom_range(4000));
			if ($urandom_range(49) == 0)
				clock_us = 48'({$urandom, $urandom});
			it.now_us = clock_us;
			it.median_latency = pick_latency();
			it.tail_latency = pick_latency();
			it.mean_latency = $urandom;
			it.stats_present = ($urandom_range(9) != 0);
			send_item(it);
		end
	endtask

	task automatic test_directed();
		tick_node(4'd5, 48'd1, 32'd0, 32'd0, 32'd0, 1'b1);          // unregistered
		reg_node(4'd0, POL_CONSERV, 32'h0001_0000, 32'hFFFF_FFFF);
		reg_node(4'd0, POL_AGGRESS, 32'd5, 32'd7);                   // repeat, ignored
		reg_node(4'd1, POL_FIXED, 32'h800, 32'h1000);
		tick_node(4'd1, 48'd5, 32'd0, 32'd0, 32'd0, 1'b1);          // fixed node
		reg_node(4'd2, POL_AGGRESS, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		reg_node(4'd3, POL_HOLD, 32'h4000, 32'hFFFF_FFFF);
		reg_node(4'd4, POL_CONSERV, 32'd0, 32'h800);
		tick_node(4'd0, 48'd10, 32'd0, 32'd2000, 32'd3, 1'b0);      // no statistics
		tick_node(4'd0, 48'd20, 32'd0, 32'd1001, 32'd3, 1'b1);      // cut
		tick_node(4'd0, 48'd30, 32'd0, 32'd1000, 32'd3, 1'b1);      // at target
		tick_node(4'd0, 48'd40, 32'd0, 32'd500, 32'd3, 1'b1);       // exactly half
		tick_node(4'd0, 48'd50, 32'd0, 32'd499, 32'd3, 1'b1);       // raise
		tick_node(4'd2, 48'd60, 32'd1001, 32'd0, 32'd3, 1'b1);      // cut
		tick_node(4'd2, 48'd70, 32'd330, 32'd0, 32'd3, 1'b1);       // exactly 33%
		tick_node(4'd2, 48'd80, 32'd329, 32'd0, 32'd3, 1'b1);       // raise
		tick_node(4'd2, 48'd90, 32'd0, 32'd0, 32'd3, 1'b1);         // raise into ceiling
		tick_node(4'd3, 48'd100, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		tick_node(4'd4, 48'd110, 32'd0, 32'd0, 32'd0, 1'b1);        // zero rate up to floor
		// cut refused at the floor, then time wraps around
		tick_node(4'd4, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 1'b1);
		tick_node(4'd4, 48'd5, 32'd0, 32'd0, 32'd2, 1'b1);
	endtask

	task automatic test_reset_defaults();
		send_idle = 0;
		stall_pct = 0;
		random_phase(120, -1);
	endtask

	task automatic test_config_sweep();
		send_idle = 46;
		stall_pct = 0;
		apply_settings(32'd5000, 32'd0, 32'h00FF_FFFF, 32'd500, 32'd2000);
		random_phase(100, -1);
		// floor above ceiling, cooldown at its 32-bit maximum
		send_idle = 0;
		stall_pct = 46;
		apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_1000, 32'd0, 32'hFFFF_FFFF);
		random_phase(100, -1);
		send_idle = 32;
		stall_pct = 32;
		apply_settings(32'd0, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
		random_phase(60, -1);
		apply_settings(32'd800, 32'd256, 32'h8000_0000, 32'd100, 32'd300);
		random_phase(120, -1);
		send_idle = 46;
		stall_pct = 46;
		apply_settings(32'd1000, 32'd0, 32'd0, 32'd0, 32'd0);
		random_phase(100, -1);
	endtask

	task automatic test_drain_pause();
		send_idle = 0;
		stall_pct = 32;
		apply_settings(LATENCY_TARGET_RST, RATE_FLOOR_RST, RATE_CEILING_RST, 32'd0, 32'd0);
		random_phase(110, 55);
	endtask

	// Report checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got.status = status_t'(m_tuser);
			got.rate_now = m_tdata[31:0];
			got.resync = m_tdata[32];
			got.adjust_total = m_tdata[64:33];
			got.lowest_rate = m_tdata[96:65];
			got.highest_rate = m_tdata[128:97];
			got.recent_tail = m_tdata[160:129];
			got.recent_mean = m_tdata[192:161];
			if (due_reports.size() == 0) begin
				bad_reports++;
				if (bad_reports <= 10)
					$display("unexpected report: status %0d rate %h", m_tuser, got.rate_now);
			end else begin
				want = due_reports.pop_front();
				if (got.status !== want.status || got.rate_now !== want.rate_now
					|| got.resync !== want.resync || got.adjust_total !== want.adjust_total
					|| got.lowest_rate !== want.lowest_rate
					|| got.highest_rate !== want.highest_rate
					|| got.recent_tail !== want.recent_tail
					|| got.recent_mean !== want.recent_mean) begin
					bad_reports++;
					if (bad_reports <= 10) begin
						$display("mismatch exp: st %0d rate %h rs %0d cnt %h lo %h hi %h tail %h mean %h",
							want.status, want.rate_now, want.resync, want.adjust_total,
							want.lowest_rate, want.highest_rate, want.recent_tail,
							want.recent_mean);
						$display("         got: st %0d rate %h rs %0d cnt %h lo %h hi %h tail %h mean %h",
							got.status, got.rate_now, got.resync, got.adjust_total,
							got.lowest_rate, got.highest_rate, got.recent_tail,
							got.recent_mean);
					end
				end
			end
		end
	end

	// Watchdog: too long without any handshake
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL latency_driven_rate_tuner_unit");
			$finish;
		end
	end

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_reset_defaults();
		test_config_sweep();
		test_drain_pause();
		drain_results();
		repeat (8) @(negedge clk);
		if (bad_reports == 0 && due_reports.size() == 0)
			$display("PASS latency_driven_rate_tuner_unit");
		else
			$display("FAIL latency_driven_rate_tuner_unit");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/lrt_pkg.sv
hw/rtl/lrt_cfg.sv
hw/rtl/lrt_table.sv
hw/rtl/lrt_eval.sv
hw/rtl/latency_driven_rate_tuner_unit.sv
sim/tb.sv
